FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising clk edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types and constants of the streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

    // Command queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_SYMBOL_62  = 2'd0;
    localparam logic [1:0] CFG_SYMBOL_63  = 2'd1;
    localparam logic [1:0] CFG_PAD_SYMBOL = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // One output character to be produced: a six-bit value or a pad
    typedef struct packed {
        logic       is_pad;
        logic [5:0] sextet;
    } slot_t;

    // Work for one accepted byte: slots 0..last_slot are emitted in order
    typedef struct packed {
        logic [1:0]      last_slot;
        logic            msg_end;
        slot_t [3:0]     slots;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Tracks group phase and leftover bits, turns each byte into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front
    import b64enc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     acc,
    input  wire in_item_t item,
    output cmd_t          cmd
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        case (phase_reg)
            PH1:
            begin
                cmd.slots[0].sextet = {carry_reg[1:0], item.data_byte[7:4]};
                if (item.last_byte)
                begin
                    cmd.slots[1].sextet = {item.data_byte[3:0], 2'b00};
                    cmd.slots[2].is_pad = 1'b1;
                    cmd.last_slot       = 2'd2;
                    cmd.msg_end         = 1'b1;
                    phase_next          = PH0;
                    carry_next          = 4'd0;
                end
                else
                begin
                    phase_next = PH2;
                    carry_next = item.data_byte[3:0];
                end
            end
            PH2:
            begin
                cmd.slots[0].sextet = {carry_reg, item.data_byte[7:6]};
                cmd.slots[1].sextet = item.data_byte[5:0];
                cmd.last_slot       = 2'd1;
                cmd.msg_end         = item.last_byte;
                phase_next          = PH0;
                carry_next          = 4'd0;
            end
            default:
            begin
                // phase 0, and the unused code treated likewise
                cmd.slots[0].sextet = item.data_byte[7:2];
                if (item.last_byte)
                begin
                    cmd.slots[1].sextet = {item.data_byte[1:0], 4'b0000};
                    cmd.slots[2].is_pad = 1'b1;
                    cmd.slots[3].is_pad = 1'b1;
                    cmd.last_slot       = 2'd3;
                    cmd.msg_end         = 1'b1;
                    phase_next          = PH0;
                    carry_next          = 4'd0;
                end
                else
                begin
                    phase_next = PH1;
                    carry_next = {2'b00, item.data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            carry_reg <= 4'd0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    // a message end always restarts the group
    `ASSERT_CLK(a_last_restarts, (acc && item.last_byte) |=> (phase_reg == PH0 && carry_reg == 4'd0), "group not restarted after last byte")

endmodule

`default_nettype wire

FILE: design/b64enc_cmdq.sv
// ----------------------------------------------------------------------------
// b64enc_cmdq
// Short command queue parting the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_cmdq
    import b64enc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

`include "assert_macros.svh"

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, push && full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Emits one character per cycle from queued commands while not stalled; holds the symbol regs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back
    import b64enc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       head,
    input  wire logic       empty,
    output logic            pop,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data
);

`include "assert_macros.svh"

    logic [7:0] sym62_reg, sym63_reg, pad_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg, out_data_next;
    slot_t      cur;
    logic       load, emit, at_end;

    function automatic logic [7:0] map_sextet(input logic [5:0] v,
                                              input logic [7:0] s62,
                                              input logic [7:0] s63);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'h41;
        else if (v < 6'd52)
            return w + 8'd71;      // 'a' at 26
        else if (v < 6'd62)
            return w - 8'd4;       // '0' at 52
        else if (v == 6'd62)
            return s62;
        else
            return s63;
    endfunction

    assign cur    = head.slots[idx_reg];
    assign at_end = (idx_reg == head.last_slot);
    assign load   = !out_valid_reg || !out_stall;
    assign emit   = load && !empty;
    assign pop    = emit && at_end;

    always_comb
    begin
        out_data_next.out_char = cur.is_pad ? pad_reg
                                            : map_sextet(cur.sextet, sym62_reg, sym63_reg);
        out_data_next.out_last = head.msg_end && at_end;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym62_reg     <= 8'd45;
            sym63_reg     <= 8'd126;
            pad_reg       <= 8'd61;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYMBOL_62:  sym62_reg <= cfg_data;
                    CFG_SYMBOL_63:  sym63_reg <= cfg_data;
                    CFG_PAD_SYMBOL: pad_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (load)
            begin
                out_valid_reg <= !empty;
            end
            if (emit)
            begin
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_CLK(a_idx_in_range, !empty |-> (idx_reg <= head.last_slot), "slot index past end")
    `ASSERT_CLK(a_pop_rewinds, pop |=> (idx_reg == 2'd0), "slot index not rewound on pop")

endmodule

`default_nettype wire

FILE: design/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder: one byte in per transaction, one character out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data   (data_byte, last_byte)
// out       output     out_valid / out_stall out_data  (out_char, out_last)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// - One character leaves per cycle while out_stall is low; a byte yields 1 or 2
//   characters, 2 to 4 on the last byte. The single output register is the
//   bottleneck.
// - An input transaction is taken whenever the two-entry command queue has
//   room, so the front keeps taking bytes while the output is stalled, until the queue fills.
// - An accepted byte passes the command queue, then the output register.
// - Reset (rst_n, asynchronous): group phase and leftover bits cleared, queue
//   emptied, symbol registers back to '-', '~' and '='.
// - cfg_ready is always high; index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_top
    import b64enc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    // character output
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    // register writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic in_acc;
    cmd_t front_cmd;
    cmd_t q_head;
    logic q_full, q_empty, q_pop;

    // front stalls only on a full queue
    assign in_stall  = q_full;
    assign in_acc    = in_valid && !q_full;
    assign cfg_ready = 1'b1;

    b64enc_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .acc  (in_acc),
        .item (in_data),
        .cmd  (front_cmd)
    );

    b64enc_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_acc),
        .push_cmd(front_cmd),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // back walks each command's slots, one character per free output cycle
    b64enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming base64 encoder: drives byte
// transactions, predicts every character from its own encoder model and
// compares each output transaction in order, under varied idling and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import b64enc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;   // far beyond the slowest legal run
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;      // settle time after the last character

    // Index that decodes to no register
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Position of the next byte within its 3-byte group
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Register reset values
    localparam logic [7:0] SYM62_RESET = 8'd45;
    localparam logic [7:0] SYM63_RESET = 8'd126;
    localparam logic [7:0] PAD_RESET   = 8'd61;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    base64_stream_encoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Encoder prediction: own copy of the group state and symbol registers
    // ------------------------------------------------------------------------
    logic [1:0] enc_phase = PHASE_FIRST;
    logic [3:0] enc_carry = '0;
    logic [7:0] sym_62    = SYM62_RESET;
    logic [7:0] sym_63    = SYM63_RESET;
    logic [7:0] pad_char  = PAD_RESET;

    out_item_t expected_chars[$];

    int errors        = 0;
    int bytes_sent    = 0;
    int chars_checked = 0;
    int messages_sent = 0;
    int cycle_count   = 0;

    // Percentages of cycles in which the sender idles / the receiver stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic hold_request = 1'b0;
    logic rx_hold      = 1'b0;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + 8'(v);
        else if (v < 6'd52)
            return 8'h61 + 8'(v - 6'd26);
        else if (v < 6'd62)
            return 8'h30 + 8'(v - 6'd52);
        else if (v == 6'd62)
            return sym_62;
        return sym_63;
    endfunction

    function automatic void queue_char(input logic [7:0] c, input logic last);
        out_item_t e;
        e.out_char = c;
        e.out_last = last;
        expected_chars.push_back(e);
    endfunction

    // Work out the characters one accepted byte produces, and step the state
    task automatic encode_byte(input in_item_t item);
        logic [7:0] b;
        b = item.data_byte;
        case (enc_phase)
            PHASE_SECOND:
            begin
                queue_char(sextet_to_char({enc_carry[1:0], b[7:4]}), 1'b0);
                if (item.last_byte)
                begin
                    queue_char(sextet_to_char({b[3:0], 2'b00}), 1'b0);
                    queue_char(pad_char, 1'b1);
                    enc_phase = PHASE_FIRST;
                    enc_carry = '0;
                end
                else
                begin
                    enc_carry = b[3:0];
                    enc_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD:
            begin
                queue_char(sextet_to_char({enc_carry, b[7:6]}), 1'b0);
                queue_char(sextet_to_char(b[5:0]), item.last_byte);
                enc_phase = PHASE_FIRST;
                enc_carry = '0;
            end
            default:
            begin
                // first byte of a group; the unused phase value behaves the same
                queue_char(sextet_to_char(b[7:2]), 1'b0);
                if (item.last_byte)
                begin
                    queue_char(sextet_to_char({b[1:0], 4'b0000}), 1'b0);
                    queue_char(pad_char, 1'b0);
                    queue_char(pad_char, 1'b1);
                    enc_phase = PHASE_FIRST;
                    enc_carry = '0;
                end
                else
                begin
                    enc_carry = {2'b00, b[1:0]};
                    enc_phase = PHASE_SECOND;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= rx_hold || ($urandom_range(0, 99) < recv_stall_pct);

    // Long hold-off, timed here so the sender keeps offering bytes meanwhile
    initial
    begin
        forever
        begin
            wait (hold_request);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
            hold_request = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: each character transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected character: actual char=%02h last=%0b",
                         $time, out_data.out_char, out_data.out_last);
            end
            else
            begin
                e = expected_chars.pop_front();
                chars_checked++;
                if (out_data.out_char !== e.out_char)
                begin
                    errors++;
                    $display("%0t: out_char mismatch: expected %02h actual %02h",
                             $time, e.out_char, out_data.out_char);
                end
                if (out_data.out_last !== e.out_last)
                begin
                    errors++;
                    $display("%0t: out_last mismatch: expected %0b actual %0b",
                             $time, e.out_last, out_data.out_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d characters still awaited",
                     $time, expected_chars.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offer one byte transaction; valid stays high into the next call unless
    // the sender decides to idle first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t item;
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte = b;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        encode_byte(item);
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    // Random message; bytes are often pushed high so sextets 62 and 63 turn up
    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                b = b | 8'hF8;
            send_byte(b, i == len - 1);
        end
    endtask

    // Sender pauses until every awaited character has come out
    task automatic wait_drained();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SYMBOL_62:  sym_62   = value;
            CFG_SYMBOL_63:  sym_63   = value;
            CFG_PAD_SYMBOL: pad_char = value;
            default: ;      // unused index leaves everything alone
        endcase
    endtask

    // Write all three symbol registers back to back; only while idle
    task automatic apply_symbols(input logic [7:0] s62, input logic [7:0] s63,
                                 input logic [7:0] pad);
        write_reg(CFG_SYMBOL_62, s62);
        write_reg(CFG_SYMBOL_63, s63);
        write_reg(CFG_PAD_SYMBOL, pad);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset symbols, every short-message ending, sextets 0, 62 and 63,
    // multi-group messages and the phase returning to the start
    task automatic test_directed_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b1);                 // last in first phase: two pads
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);                 // last in second phase: one pad
        send_byte(8'h61, 1'b1);
        send_byte(8'hFB, 1'b0);                 // all four sextets 62
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);                 // last in third phase: no pad
        send_byte(8'hFF, 1'b0);                 // all sextets 63, then zeros
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h69, 1'b1);
        send_byte(8'h64, 1'b0);                 // upper, lower and digit ranges
        send_byte(8'hA6, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'h1E, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_drained();
    endtask

    // A write to the unused index must change nothing
    task automatic test_unused_index();
        write_reg(CFG_UNUSED, 8'h00);
        write_reg(CFG_UNUSED, 8'hFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFC, 1'b1);
        wait_drained();
    endtask

    // Several symbol settings, the extremes among them, then back to reset
    task automatic test_symbol_settings();
        logic [7:0] s62;
        logic [7:0] s63;
        logic [7:0] pad;
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0: begin s62 = 8'h00; s63 = 8'hFF; pad = 8'h00; end
                1: begin s62 = 8'hFF; s63 = 8'h00; pad = 8'hFF; end
                default:
                begin
                    s62 = 8'($urandom_range(0, 255));
                    s63 = 8'($urandom_range(0, 255));
                    pad = 8'($urandom_range(0, 255));
                end
            endcase
            apply_symbols(s62, s63, pad);
            for (int m = 0; m < 3; m++)
                send_message($urandom_range(1, 4));
            wait_drained();
        end
        apply_symbols(SYM62_RESET, SYM63_RESET, PAD_RESET);
    endtask

    // Random messages under each idling pattern, gaps falling on every phase
    task automatic test_idle_mix();
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int m = 0; m < 5; m++)
                send_message($urandom_range(1, 7));
            wait_drained();
        end
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        for (int m = 0; m < 5; m++)
            send_message($urandom_range(2, 6));
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_unused_index();
        test_symbol_settings();
        test_idle_mix();
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            errors++;
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
        end

        $display("Encoded %0d bytes in %0d messages, %0d characters checked,",
                 bytes_sent, messages_sent, chars_checked);
        $display("over symbol settings, idle and stall mixes and a long output hold-off.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
